// ===== hdl/split_prefetch_buffer_assert.svh =====
// Assertion macros shared by the prefetch buffer RTL.
`ifndef SPLIT_PREFETCH_BUFFER_ASSERT_SVH
`define SPLIT_PREFETCH_BUFFER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/spb_pkg.sv =====
// Package of shared constants and types for the split prefetch buffer.
package spb_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int SLOTS_DEF     = 5;
    localparam int FIELD_BITS    = 32;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_FILL   = 1'b1;

    // Request presented to one buffer side from the input stage.
    typedef struct packed {
        logic                  go;
        logic                  fill;
        logic                  enable;
        logic [FIELD_BITS-1:0] addr;
        logic [FIELD_BITS-1:0] word;
    } spb_req_t;

    // Old contents of the addressed slot and the tag compare result.
    typedef struct packed {
        logic                  present;
        logic                  tag_nonzero;
        logic [FIELD_BITS-1:0] tag;
        logic [FIELD_BITS-1:0] word;
    } spb_resp_t;

endpackage

// ===== hdl/split_prefetch_buffer.sv =====
// Top level of the split instruction/data prefetch buffer.
//
// Usage: each request on the s_ channel is a lookup (s_mode 0) or a fill
// (s_mode 1) aimed at the instruction side (s_is_instruction 1) or the data
// side. Every request yields exactly one result on the m_ channel: hit flag,
// read word, and for data fills that evict a slot with a nonzero tag the old
// address and word to write back to memory.
// cfg_valid/cfg_ready/cfg_prefetch_enable write the enable bit; cfg_ready is
// always high. With the enable clear, lookups miss and fills change nothing.
// Path: an accepted request is held in the input register and then moves to
// the result register on m_ once that register is free or being drained.
// Throughput: one request per cycle while the sink takes results; the input
// register and the result register form a two-stage pipe, and the slot read,
// tag compare and slot write all happen between them, as the request moves
// on, so each request sees every earlier write.
// Reset (aresetn low, synchronous) empties both pipeline stages, clears all
// tags and words to zero and sets the enable bit. After reset address zero
// therefore hits with a zero word.
// When m_ready stays low, the result register holds, the input register
// fills once more and s_ready then drops until the sink takes the result.
`include "split_prefetch_buffer_assert.svh"

module split_prefetch_buffer
    import spb_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int SLOTS     = SLOTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_prefetch_enable,
    // request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic                  s_is_instruction,
    input  logic [FIELD_BITS-1:0] s_address,
    input  logic [FIELD_BITS-1:0] s_fill_word,
    // result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_hit,
    output logic [FIELD_BITS-1:0] m_read_word,
    output logic                  m_writeback_valid,
    output logic [FIELD_BITS-1:0] m_writeback_address,
    output logic [FIELD_BITS-1:0] m_writeback_word
);

    // enable register
    logic enable_reg;

    // input stage
    logic                  in_vld_reg;
    logic                  mode_reg;
    logic                  inst_reg;
    logic [FIELD_BITS-1:0] addr_reg;
    logic [FIELD_BITS-1:0] word_reg;

    // result stage
    logic                  out_vld_reg;
    logic                  hit_reg,  hit_next;
    logic [FIELD_BITS-1:0] rd_reg,   rd_next;
    logic                  wbv_reg,  wbv_next;
    logic [FIELD_BITS-1:0] wba_reg,  wba_next;
    logic [FIELD_BITS-1:0] wbw_reg,  wbw_next;

    logic      advance;
    spb_req_t  inst_req,  data_req;
    spb_resp_t inst_resp, data_resp, sel_resp;
    logic      is_fill;

    assign cfg_ready = 1'b1;

    // Move the input stage on whenever the result register is free or drains.
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            enable_reg <= cfg_prefetch_enable;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    // Payload of the input stage: capture only on acceptance.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            inst_reg <= s_is_instruction;
            addr_reg <= s_address;
            word_reg <= s_fill_word;
        end
    end

    // Steer the request to one side only; the other side just reads.
    always_comb begin
        is_fill         = (mode_reg == MODE_FILL);
        inst_req.go     = advance && inst_reg;
        inst_req.fill   = is_fill;
        inst_req.enable = enable_reg;
        inst_req.addr   = addr_reg;
        inst_req.word   = word_reg;
        data_req        = inst_req;
        data_req.go     = advance && !inst_reg;
    end

    spb_side #(
        .WORD_BITS (WORD_BITS),
        .SLOTS     (SLOTS)
    ) u_inst_side (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (inst_req),
        .resp    (inst_resp)
    );

    spb_side #(
        .WORD_BITS (WORD_BITS),
        .SLOTS     (SLOTS)
    ) u_data_side (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (data_req),
        .resp    (data_resp)
    );

    // Form the result from the selected side's old slot contents.
    always_comb begin
        sel_resp = inst_reg ? inst_resp : data_resp;
        hit_next = sel_resp.present;
        rd_next  = (!is_fill && sel_resp.present) ? sel_resp.word : '0;
        wbv_next = is_fill && enable_reg && !sel_resp.present && !inst_reg
                   && sel_resp.tag_nonzero;
        wba_next = wbv_next ? sel_resp.tag  : '0;
        wbw_next = wbv_next ? sel_resp.word : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            hit_reg <= hit_next;
            rd_reg  <= rd_next;
            wbv_reg <= wbv_next;
            wba_reg <= wba_next;
            wbw_reg <= wbw_next;
        end
    end

    assign m_valid             = out_vld_reg;
    assign m_hit               = hit_reg;
    assign m_read_word         = rd_reg;
    assign m_writeback_valid   = wbv_reg;
    assign m_writeback_address = wba_reg;
    assign m_writeback_word    = wbw_reg;

    `SPB_ASSERT_SAME(a_wb_not_hit, m_valid && m_writeback_valid, !m_hit,
        "write-back reported on a hit")
    `SPB_ASSERT_SAME(a_wb_tag_nonzero, m_valid && m_writeback_valid,
        m_writeback_address != '0, "write-back of a zero tag")
    `SPB_ASSERT_SAME(a_read_needs_hit, m_valid && (m_read_word != '0), m_hit,
        "nonzero read word without a hit")
    `SPB_ASSERT_NEXT(a_input_held, in_vld_reg && !advance, in_vld_reg,
        "stalled request dropped from the input stage")

endmodule

// ===== hdl/spb_side.sv =====
// One side of the prefetch buffer: direct-mapped tag and word store.
module spb_side
    import spb_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int SLOTS     = SLOTS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  spb_req_t  req,
    output spb_resp_t resp
);

    localparam int STORE_BITS = (WORD_BITS < FIELD_BITS) ? WORD_BITS : FIELD_BITS;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [STORE_BITS-1:0] tags_reg  [SLOTS];
    logic [STORE_BITS-1:0] words_reg [SLOTS];

    logic [SLOT_W-1:0]     slot;
    logic [STORE_BITS-1:0] addr_cut;
    logic [STORE_BITS-1:0] word_cut;
    logic [STORE_BITS-1:0] tag_rd;
    logic [STORE_BITS-1:0] word_rd;
    logic                  present;
    logic                  install;

    always_comb begin
        addr_cut = req.addr[STORE_BITS-1:0];
        word_cut = req.word[STORE_BITS-1:0];
        // Slot from the low nibble through a 16-entry constant table.
        slot     = '0;
        for (int k = 0; k < 16; k++) begin
            if (req.addr[3:0] == 4'(k)) slot = SLOT_W'(k % SLOTS);
        end
        tag_rd   = tags_reg[slot];
        word_rd  = words_reg[slot];
        present  = req.enable && (tag_rd == addr_cut);
        install  = req.go && req.fill && req.enable && !present;
    end

    always_comb begin
        resp.present     = present;
        resp.tag_nonzero = (tag_rd != '0);
        resp.tag         = FIELD_BITS'(tag_rd);
        resp.word        = FIELD_BITS'(word_rd);
    end

    // Replace the slot on a fill miss; the store clears to zero on reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                tags_reg[i]  <= '0;
                words_reg[i] <= '0;
            end
        end else if (install) begin
            tags_reg[slot]  <= addr_cut;
            words_reg[slot] <= word_cut;
        end
    end

endmodule

// ===== tb/sv/split_prefetch_buffer_tb.sv =====
// Self-checking testbench for the split instruction/data prefetch buffer.
module split_prefetch_buffer_tb
    import spb_pkg::*;
();

    // One result as seen on the m_ channel.
    typedef struct packed {
        logic                  hit;
        logic [FIELD_BITS-1:0] read_word;
        logic                  wb_valid;
        logic [FIELD_BITS-1:0] wb_address;
        logic [FIELD_BITS-1:0] wb_word;
    } prefetch_result_t;

    // Shadow copy of both buffer sides plus the queue of results still owed.
    class prefetch_scoreboard;
        logic [FIELD_BITS-1:0] inst_tag   [SLOTS_DEF];
        logic [FIELD_BITS-1:0] inst_word  [SLOTS_DEF];
        logic [FIELD_BITS-1:0] data_tag   [SLOTS_DEF];
        logic [FIELD_BITS-1:0] data_word  [SLOTS_DEF];
        logic                  enabled;
        prefetch_result_t      owed_q[$];
        int errors;
        int requests;
        int fills;
        int hits;
        int writebacks;
        int disabled_requests;

        function new();
            for (int i = 0; i < SLOTS_DEF; i++) begin
                inst_tag[i]  = '0;
                inst_word[i] = '0;
                data_tag[i]  = '0;
                data_word[i] = '0;
            end
            enabled = 1'b1;
        endfunction

        function void set_enable(logic value);
            enabled = value;
        endfunction

        // Work out the result of one accepted request and update the shadow slots.
        function void note_request(logic mode, logic side, logic [FIELD_BITS-1:0] addr,
                                   logic [FIELD_BITS-1:0] word);
            prefetch_result_t want;
            int               slot;
            logic             present;
            slot    = addr[3:0] % SLOTS_DEF;
            want    = '0;
            present = enabled && ((side ? inst_tag[slot] : data_tag[slot]) == addr);
            want.hit = present;
            if (mode == MODE_LOOKUP) begin
                if (present)
                    want.read_word = side ? inst_word[slot] : data_word[slot];
            end else if (enabled && !present) begin
                if (side) begin
                    inst_tag[slot]  = addr;
                    inst_word[slot] = word;
                end else begin
                    if (data_tag[slot] != '0) begin
                        want.wb_valid   = 1'b1;
                        want.wb_address = data_tag[slot];
                        want.wb_word    = data_word[slot];
                    end
                    data_tag[slot]  = addr;
                    data_word[slot] = word;
                end
            end
            requests++;
            if (mode == MODE_FILL) fills++;
            if (want.hit) hits++;
            if (want.wb_valid) writebacks++;
            if (!enabled) disabled_requests++;
            owed_q.push_back(want);
        endfunction

        function void compare_field(string field, logic [FIELD_BITS-1:0] want,
                                    logic [FIELD_BITS-1:0] got);
            if (want !== got) begin
                $display("%0t: %s expected %h actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(prefetch_result_t got);
            prefetch_result_t want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result expected none actual %p", $time, got);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            compare_field("hit", FIELD_BITS'(want.hit), FIELD_BITS'(got.hit));
            compare_field("read_word", want.read_word, got.read_word);
            compare_field("writeback_valid", FIELD_BITS'(want.wb_valid),
                          FIELD_BITS'(got.wb_valid));
            compare_field("writeback_address", want.wb_address, got.wb_address);
            compare_field("writeback_word", want.wb_word, got.wb_word);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    localparam logic SIDE_DATA      = 1'b0;
    localparam logic SIDE_INST      = 1'b1;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   TAIL_CYCLES    = 16;
    localparam int   POOL_SIZE      = 12;
    localparam int   PHASES         = 7;
    localparam int   PHASE_ITEMS    = 280;
    localparam int   HOLD_OFF       = 300;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic                  cfg_prefetch_enable;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_mode;
    logic                  s_is_instruction;
    logic [FIELD_BITS-1:0] s_address;
    logic [FIELD_BITS-1:0] s_fill_word;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_hit;
    logic [FIELD_BITS-1:0] m_read_word;
    logic                  m_writeback_valid;
    logic [FIELD_BITS-1:0] m_writeback_address;
    logic [FIELD_BITS-1:0] m_writeback_word;

    prefetch_scoreboard    ledger = new();
    prefetch_result_t      seen;
    logic [FIELD_BITS-1:0] addr_pool [POOL_SIZE];
    bit                    send_gaps;
    bit                    sink_stalls;
    int                    hold_request;
    int                    idle_cycles;

    split_prefetch_buffer DUT (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_prefetch_enable (cfg_prefetch_enable),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_mode              (s_mode),
        .s_is_instruction    (s_is_instruction),
        .s_address           (s_address),
        .s_fill_word         (s_fill_word),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_hit               (m_hit),
        .m_read_word         (m_read_word),
        .m_writeback_valid   (m_writeback_valid),
        .m_writeback_address (m_writeback_address),
        .m_writeback_word    (m_writeback_word)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Gap length: mostly none, sometimes short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one request, optionally after an idle gap, and hold it until accepted.
    // Valid stays high across back-to-back requests; only the payload moves.
    task automatic send_request(input logic mode, input logic side,
                                input logic [FIELD_BITS-1:0] addr,
                                input logic [FIELD_BITS-1:0] word);
        int gap;
        gap = send_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_mode           <= mode;
        s_is_instruction <= side;
        s_address        <= addr;
        s_fill_word      <= word;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait for every owed result; step the clock first so the
    // monitor has logged the last accepted request.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (ledger.pending() != 0) @(posedge aclk);
    endtask

    // Write the enable bit; only ever called with the pipe empty.
    task automatic write_enable(input logic value);
        cfg_valid           <= 1'b1;
        cfg_prefetch_enable <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Fill the pool with a mix of tiny, zero and wide addresses so that
    // lookups hit often and fills keep evicting one another.
    task automatic refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            case ($urandom_range(3))
                0: addr_pool[i] = '0;
                1: addr_pool[i] = $urandom_range(1, 40);
                default: addr_pool[i] = $urandom;
            endcase
        end
    endtask

    task automatic random_request();
        logic [FIELD_BITS-1:0] addr;
        if ($urandom_range(3) == 0)
            addr = $urandom;
        else
            addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
        send_request($urandom_range(1) ? MODE_FILL : MODE_LOOKUP,
                     $urandom_range(1) ? SIDE_INST : SIDE_DATA, addr, $urandom);
    endtask

    // Sink: stall at random, or hold off for a long stretch when asked, so the
    // result register backs up and s_ready has to drop.
    initial begin
        int stall_left;
        stall_left = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (sink_stalls) stall_left = pick_gap();
            end
            @(posedge aclk);
        end
    end

    // Monitor: log accepted requests and configuration writes, check results.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                ledger.set_enable(cfg_prefetch_enable);
            if (s_valid && s_ready)
                ledger.note_request(s_mode, s_is_instruction, s_address, s_fill_word);
            if (m_valid && m_ready) begin
                seen.hit        = m_hit;
                seen.read_word  = m_read_word;
                seen.wb_valid   = m_writeback_valid;
                seen.wb_address = m_writeback_address;
                seen.wb_word    = m_writeback_word;
                ledger.check_result(seen);
            end
        end
    end

    // Watchdog: give up after a long run of cycles with no handshake at all.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles, %0d results owed",
                     idle_cycles, ledger.pending());
            $display("split_prefetch_buffer: mismatch");
            $finish;
        end
    end

    initial begin
        aresetn             = 1'b0;
        cfg_valid           = 1'b0;
        cfg_prefetch_enable = 1'b1;
        s_valid             = 1'b0;
        s_mode              = MODE_LOOKUP;
        s_is_instruction    = SIDE_DATA;
        s_address           = '0;
        s_fill_word         = '0;
        m_ready             = 1'b0;
        send_gaps           = 1'b0;
        sink_stalls         = 1'b0;
        hold_request        = 0;
        idle_cycles         = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Address zero hits with a zero word straight after reset,
        // on both sides, and a fill of it counts as already present.
        send_request(MODE_LOOKUP, SIDE_INST, 32'h0, 32'hFFFF_FFFF);
        send_request(MODE_LOOKUP, SIDE_DATA, 32'h0, 32'h0);
        send_request(MODE_FILL,   SIDE_DATA, 32'h0, 32'h1234_5678);
        // Replace a zero tag: no write-back. Then evict it: write-back of 5.
        send_request(MODE_FILL,   SIDE_DATA, 32'h5, 32'hFFFF_FFFF);
        send_request(MODE_FILL,   SIDE_DATA, 32'hA, 32'h0000_0001);
        send_request(MODE_LOOKUP, SIDE_DATA, 32'hA, 32'h0);
        send_request(MODE_FILL,   SIDE_DATA, 32'hA, 32'hDEAD_BEEF);
        // Install address zero on purpose, then evict it: still no write-back.
        send_request(MODE_FILL,   SIDE_DATA, 32'h0, 32'hCAFE_F00D);
        send_request(MODE_FILL,   SIDE_DATA, 32'hFFFF_FFF0, 32'h8000_0001);
        send_request(MODE_FILL,   SIDE_DATA, 32'h8000_0000, 32'h7FFF_FFFE);
        // Instruction fills overwrite silently.
        send_request(MODE_FILL,   SIDE_INST, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        send_request(MODE_FILL,   SIDE_INST, 32'h0000_000F, 32'h5A5A_5A5A);
        send_request(MODE_LOOKUP, SIDE_INST, 32'hFFFF_FFFF, 32'h0);
        send_request(MODE_LOOKUP, SIDE_INST, 32'h0000_000F, 32'hFFFF_FFFF);
        send_request(MODE_LOOKUP, SIDE_DATA, 32'h0000_000F, 32'h0);
        drain();

        // Buffer switched off: lookups miss, fills change nothing.
        write_enable(1'b0);
        send_request(MODE_LOOKUP, SIDE_INST, 32'h0000_000F, 32'h0);
        send_request(MODE_FILL,   SIDE_DATA, 32'h0000_0001, 32'h1111_1111);
        send_request(MODE_LOOKUP, SIDE_DATA, 32'h8000_0000, 32'h0);
        send_request(MODE_FILL,   SIDE_INST, 32'h0000_0004, 32'h2222_2222);
        drain();
        write_enable(1'b1);
        send_request(MODE_LOOKUP, SIDE_DATA, 32'h0000_0001, 32'h0);
        send_request(MODE_LOOKUP, SIDE_INST, 32'h0000_0004, 32'h0);
        send_request(MODE_LOOKUP, SIDE_DATA, 32'h8000_0000, 32'h0);
        drain();

        // Random phases. Vary idling per phase, switch the buffer off for one,
        // and hold the sink off at the start of one while requests keep coming.
        for (int phase = 0; phase < PHASES; phase++) begin
            write_enable(phase != 4);
            refresh_pool();
            send_gaps   = (phase != 1);
            sink_stalls = (phase != 1) && (phase != 5);
            if (phase == 2) hold_request = HOLD_OFF;
            repeat (phase == 4 ? PHASE_ITEMS / 2 : PHASE_ITEMS) random_request();
            drain();
        end

        // Hang on a little longer so a stray extra result would be caught.
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("covered %0d requests (%0d fills, %0d with the buffer off)",
                 ledger.requests, ledger.fills, ledger.disabled_requests);
        $display("saw %0d hits and %0d data write-backs", ledger.hits, ledger.writebacks);
        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("split_prefetch_buffer: match");
        else
            $display("split_prefetch_buffer: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/spb_pkg.sv
hdl/spb_side.sv
hdl/split_prefetch_buffer.sv
tb/sv/split_prefetch_buffer_tb.sv
